### sv/leader_election_cluster_top_defines.svh
// assertion macros used by the cluster top rtl
`ifndef LEADER_ELECTION_CLUSTER_TOP_DEFINES_SVH
`define LEADER_ELECTION_CLUSTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define LEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define LEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/lec_pkg.sv
package lec_pkg;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_t;

  localparam logic [2:0] CMD_ELECT     = 3'd0;
  localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
  localparam logic [2:0] CMD_FAIL      = 3'd2;
  localparam logic [2:0] CMD_RECOVER   = 3'd3;
  localparam logic [2:0] CMD_CLEAR_HB  = 3'd4;

  localparam logic [3:0] CLUSTER_SIZE_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_VOTE,
    ST_DECIDE,
    ST_PASS,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    OP_SCAN,
    OP_VOTE,
    OP_HB
  } unit_op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] node;
  } in_t;

  typedef struct packed {
    role_t       role;
    logic [15:0] node_term;
    logic        node_alive;
    logic [3:0]  votes;
    logic [2:0]  needed;
    logic        elected;
    logic        leader_valid;
    logic [2:0]  leader_index;
    logic        heard_heartbeat;
    logic        bad_node;
  } out_t;

endpackage

### sv/leader_election_cluster_top.sv
// Leader election cluster: simplified raft election over up to MAX_NODES nodes.
// Input: in_data (cmd, node) is taken at a clock edge with start high and
// busy low. busy stays high while the item is worked on.
// Output: one result item per input item, shown on out_data for exactly one
// cycle with out_valid high; the receiver cannot stall, so it must take it.
// Config: cfg_we/cfg_wdata write cluster_size; write only while idle.
// Timing: a start-election command on a live node runs a vote sweep and a
// heartbeat/leader sweep, one node per cycle through the shared node unit.
// Other commands, and an election on a dead or out-of-range node, run only
// the heartbeat/leader sweep. out_valid rises in the same cycle that busy
// falls, and a new item may be started in that same cycle.
// Reset: synchronous, active low; all nodes become live followers with term
// 0, no vote and no heartbeat, and cluster_size returns to 8.
module leader_election_cluster_top #(
  parameter int MAX_NODES = 8,
  parameter int TERM_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lec_pkg::in_t  in_data,
  output logic          out_valid,
  output lec_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata
);

`include "leader_election_cluster_top_defines.svh"

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int VW = CW;
  localparam int NW = (CW > 4) ? CW : 4;
  localparam int TW = TERM_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 1);

  lec_pkg::state_t state_r, state_nxt;
  logic [2:0]      cmd_r, cmd_nxt;
  logic [IW-1:0]   tgt_r, tgt_nxt;
  logic            bad_r, bad_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [TW-1:0]   term_t_r, term_t_nxt;
  logic [CW-1:0]   votes_r, votes_nxt;
  logic [CW-1:0]   live_r, live_nxt;
  logic            elect_r, elect_nxt;
  logic            elected_r, elected_nxt;
  logic            hb_en_r, hb_en_nxt;
  logic            lvalid_r, lvalid_nxt;
  logic [IW-1:0]   lidx_r, lidx_nxt;
  logic [3:0]      cluster_size_r;
  lec_pkg::out_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [NW-1:0]   eff_n;
  logic [CW-1:0]   needed_calc;
  logic [TW-1:0]   term_inc;
  logic [VW-1:0]   tgt_tag;
  logic            in_cluster;

  // store ports
  logic [IW-1:0]   s_raddr;
  lec_pkg::role_t  rd_role;
  logic [TW-1:0]   rd_term;
  logic [VW-1:0]   rd_vote;
  logic            rd_alive;
  logic            rd_hb;
  logic            s_we;
  logic [IW-1:0]   s_waddr;
  lec_pkg::role_t  s_wrole;
  logic [TW-1:0]   s_wterm;
  logic [VW-1:0]   s_wvote;
  logic            s_walive;
  logic            s_whb;

  // node unit ports
  lec_pkg::unit_op_t u_op;
  lec_pkg::role_t    u_role;
  logic [TW-1:0]     u_term;
  logic [VW-1:0]     u_vote;
  logic              u_hb;
  logic              u_upd;
  logic              u_granted;
  logic              u_live;
  logic              u_leader;

  assign eff_n = (NW'(cluster_size_r) > NW'(MAX_NODES)) ? NW'(MAX_NODES)
                                                         : NW'(cluster_size_r);
  assign needed_calc = (live_r >> 1) + CW'(1);
  assign term_inc    = (rd_term == {TW{1'b1}}) ? rd_term : rd_term + TW'(1);
  assign tgt_tag     = VW'(tgt_r) + VW'(1);
  assign in_cluster  = NW'(idx_r) < eff_n;

  lec_node_store #(
    .DEPTH(MAX_NODES),
    .TW   (TW),
    .VW   (VW),
    .IW   (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .raddr   (s_raddr),
    .rd_role (rd_role),
    .rd_term (rd_term),
    .rd_vote (rd_vote),
    .rd_alive(rd_alive),
    .rd_hb   (rd_hb),
    .we      (s_we),
    .waddr   (s_waddr),
    .wr_role (s_wrole),
    .wr_term (s_wterm),
    .wr_vote (s_wvote),
    .wr_alive(s_walive),
    .wr_hb   (s_whb)
  );

  lec_node_unit #(
    .TW(TW),
    .VW(VW),
    .IW(IW)
  ) u_unit (
    .op        (u_op),
    .cand      (tgt_r),
    .cand_term (term_t_r),
    .self_hit  (idx_r == tgt_r),
    .in_cluster(in_cluster),
    .role_i    (rd_role),
    .term_i    (rd_term),
    .vote_i    (rd_vote),
    .alive_i   (rd_alive),
    .hb_i      (rd_hb),
    .role_o    (u_role),
    .term_o    (u_term),
    .vote_o    (u_vote),
    .hb_o      (u_hb),
    .upd       (u_upd),
    .granted   (u_granted),
    .live_inc  (u_live),
    .leader_hit(u_leader)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lec_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lec_pkg::ST_LOAD;
        end
      end
      lec_pkg::ST_LOAD: begin
        if (!bad_r && cmd_r == lec_pkg::CMD_ELECT && rd_alive) begin
          state_nxt = lec_pkg::ST_VOTE;
        end else begin
          state_nxt = lec_pkg::ST_PASS;
        end
      end
      lec_pkg::ST_VOTE: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = lec_pkg::ST_DECIDE;
        end
      end
      lec_pkg::ST_DECIDE: state_nxt = lec_pkg::ST_PASS;
      lec_pkg::ST_PASS: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = lec_pkg::ST_REPORT;
        end
      end
      lec_pkg::ST_REPORT: state_nxt = lec_pkg::ST_IDLE;
      default: state_nxt = lec_pkg::ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    bad_nxt       = bad_r;
    idx_nxt       = idx_r;
    term_t_nxt    = term_t_r;
    votes_nxt     = votes_r;
    live_nxt      = live_r;
    elect_nxt     = elect_r;
    elected_nxt   = elected_r;
    hb_en_nxt     = hb_en_r;
    lvalid_nxt    = lvalid_r;
    lidx_nxt      = lidx_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    s_raddr       = tgt_r;
    s_we          = 1'b0;
    s_waddr       = tgt_r;
    s_wrole       = rd_role;
    s_wterm       = rd_term;
    s_wvote       = rd_vote;
    s_walive      = rd_alive;
    s_whb         = rd_hb;
    u_op          = lec_pkg::OP_SCAN;
    case (state_r)
      lec_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_data.cmd;
          tgt_nxt = IW'(in_data.node);
          bad_nxt = NW'(in_data.node) >= eff_n;
        end
      end
      lec_pkg::ST_LOAD: begin
        idx_nxt     = '0;
        lvalid_nxt  = 1'b0;
        lidx_nxt    = '0;
        elect_nxt   = 1'b0;
        elected_nxt = 1'b0;
        hb_en_nxt   = 1'b0;
        if (!bad_r) begin
          case (cmd_r)
            lec_pkg::CMD_ELECT: begin
              if (rd_alive) begin
                s_we       = 1'b1;
                s_wterm    = term_inc;
                s_wrole    = lec_pkg::ROLE_CANDIDATE;
                s_wvote    = tgt_tag;
                term_t_nxt = term_inc;
                votes_nxt  = CW'(1);
                live_nxt   = '0;
                elect_nxt  = 1'b1;
              end
            end
            lec_pkg::CMD_HEARTBEAT: begin
              if (rd_alive && rd_role == lec_pkg::ROLE_LEADER) begin
                hb_en_nxt  = 1'b1;
                term_t_nxt = rd_term;
              end
            end
            lec_pkg::CMD_FAIL: begin
              s_we     = 1'b1;
              s_walive = 1'b0;
              s_wrole  = lec_pkg::ROLE_FOLLOWER;
            end
            lec_pkg::CMD_RECOVER: begin
              s_we     = 1'b1;
              s_walive = 1'b1;
              s_wterm  = '0;
              s_wvote  = '0;
              s_whb    = 1'b0;
            end
            lec_pkg::CMD_CLEAR_HB: begin
              s_we  = 1'b1;
              s_whb = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      lec_pkg::ST_VOTE: begin
        s_raddr   = idx_r;
        u_op      = lec_pkg::OP_VOTE;
        s_waddr   = idx_r;
        s_we      = u_upd;
        s_wrole   = u_role;
        s_wterm   = u_term;
        s_wvote   = u_vote;
        s_whb     = u_hb;
        votes_nxt = votes_r + CW'(u_granted);
        live_nxt  = live_r + CW'(u_live);
        idx_nxt   = idx_r + IW'(1);
      end
      lec_pkg::ST_DECIDE: begin
        idx_nxt = '0;
        s_we    = 1'b1;
        if (votes_r >= needed_calc) begin
          s_wrole     = lec_pkg::ROLE_LEADER;
          elected_nxt = 1'b1;
          hb_en_nxt   = 1'b1;
        end else begin
          s_wrole = lec_pkg::ROLE_FOLLOWER;
        end
      end
      lec_pkg::ST_PASS: begin
        // heartbeat (when enabled) and leader search share one sweep
        s_raddr = idx_r;
        u_op    = hb_en_r ? lec_pkg::OP_HB : lec_pkg::OP_SCAN;
        s_waddr = idx_r;
        s_we    = u_upd;
        s_wrole = u_role;
        s_wterm = u_term;
        s_wvote = u_vote;
        s_whb   = u_hb;
        if (u_leader && !lvalid_r) begin
          lvalid_nxt = 1'b1;
          lidx_nxt   = idx_r;
        end
        idx_nxt = idx_r + IW'(1);
      end
      lec_pkg::ST_REPORT: begin
        out_valid_nxt        = 1'b1;
        out_nxt.role         = bad_r ? lec_pkg::ROLE_FOLLOWER : rd_role;
        out_nxt.node_term    = bad_r ? 16'd0 : 16'(rd_term);
        out_nxt.node_alive   = !bad_r && rd_alive;
        out_nxt.votes        = elect_r ? 4'(votes_r) : 4'd0;
        out_nxt.needed       = elect_r ? 3'(needed_calc) : 3'd0;
        out_nxt.elected      = elected_r;
        out_nxt.leader_valid = lvalid_r;
        out_nxt.leader_index = 3'(lidx_r);
        out_nxt.heard_heartbeat = !bad_r && rd_hb;
        out_nxt.bad_node     = bad_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lec_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      cluster_size_r <= lec_pkg::CLUSTER_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cluster_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    tgt_r     <= tgt_nxt;
    bad_r     <= bad_nxt;
    idx_r     <= idx_nxt;
    term_t_r  <= term_t_nxt;
    votes_r   <= votes_nxt;
    live_r    <= live_nxt;
    elect_r   <= elect_nxt;
    elected_r <= elected_nxt;
    hb_en_r   <= hb_en_nxt;
    lvalid_r  <= lvalid_nxt;
    lidx_r    <= lidx_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != lec_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LEC_ASSERT_IMP(a_strobe_when_idle, clk, rst_n, out_valid, !busy)
  `LEC_ASSERT_NXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
  `LEC_ASSERT_IMP(a_elected_is_leader, clk, rst_n, out_valid && out_data.elected, out_data.role == lec_pkg::ROLE_LEADER && out_data.node_alive && out_data.leader_valid)
  `LEC_ASSERT_IMP(a_bad_no_election, clk, rst_n, out_valid && out_data.bad_node, out_data.votes == 4'd0 && out_data.needed == 3'd0 && !out_data.elected)

endmodule

### sv/lec_node_store.sv
module lec_node_store #(
  parameter int DEPTH = 8,
  parameter int TW    = 16,
  parameter int VW    = 4,
  parameter int IW    = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IW-1:0]        raddr,
  output lec_pkg::role_t       rd_role,
  output logic [TW-1:0]        rd_term,
  output logic [VW-1:0]        rd_vote,
  output logic                 rd_alive,
  output logic                 rd_hb,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  lec_pkg::role_t       wr_role,
  input  logic [TW-1:0]        wr_term,
  input  logic [VW-1:0]        wr_vote,
  input  logic                 wr_alive,
  input  logic                 wr_hb
);

  lec_pkg::role_t  role_r  [DEPTH];
  logic [TW-1:0]   term_r  [DEPTH];
  logic [VW-1:0]   vote_r  [DEPTH];
  logic            alive_r [DEPTH];
  logic            hb_r    [DEPTH];

  assign rd_role  = role_r[raddr];
  assign rd_term  = term_r[raddr];
  assign rd_vote  = vote_r[raddr];
  assign rd_alive = alive_r[raddr];
  assign rd_hb    = hb_r[raddr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        role_r[k]  <= lec_pkg::ROLE_FOLLOWER;
        term_r[k]  <= '0;
        vote_r[k]  <= '0;
        alive_r[k] <= 1'b1;
        hb_r[k]    <= 1'b0;
      end
    end else if (we) begin
      role_r[waddr]  <= wr_role;
      term_r[waddr]  <= wr_term;
      vote_r[waddr]  <= wr_vote;
      alive_r[waddr] <= wr_alive;
      hb_r[waddr]    <= wr_hb;
    end
  end

endmodule

### sv/lec_node_unit.sv
module lec_node_unit #(
  parameter int TW = 16,
  parameter int VW = 4,
  parameter int IW = 3
) (
  input  lec_pkg::unit_op_t op,
  input  logic [IW-1:0]     cand,
  input  logic [TW-1:0]     cand_term,
  input  logic              self_hit,
  input  logic              in_cluster,
  input  lec_pkg::role_t    role_i,
  input  logic [TW-1:0]     term_i,
  input  logic [VW-1:0]     vote_i,
  input  logic              alive_i,
  input  logic              hb_i,
  output lec_pkg::role_t    role_o,
  output logic [TW-1:0]     term_o,
  output logic [VW-1:0]     vote_o,
  output logic              hb_o,
  output logic              upd,
  output logic              granted,
  output logic              live_inc,
  output logic              leader_hit
);

  logic          part;
  logic [VW-1:0] cand_tag;

  // other live cluster members take part; the candidate itself is skipped
  assign part     = in_cluster && alive_i && !self_hit;
  assign cand_tag = VW'(cand) + VW'(1);

  always_comb begin
    role_o  = role_i;
    term_o  = term_i;
    vote_o  = vote_i;
    hb_o    = hb_i;
    upd     = 1'b0;
    granted = 1'b0;
    case (op)
      lec_pkg::OP_VOTE: begin
        if (part && !(cand_term < term_i)) begin
          upd = 1'b1;
          if (cand_term > term_i) begin
            term_o = cand_term;
            vote_o = '0;
            role_o = lec_pkg::ROLE_FOLLOWER;
          end
          if (vote_o == '0 || vote_o == cand_tag) begin
            vote_o  = cand_tag;
            granted = 1'b1;
          end
        end
      end
      lec_pkg::OP_HB: begin
        if (part && cand_term >= term_i) begin
          upd    = 1'b1;
          term_o = cand_term;
          role_o = lec_pkg::ROLE_FOLLOWER;
          vote_o = cand_tag;
          hb_o   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign live_inc   = in_cluster && alive_i;
  assign leader_hit = in_cluster && alive_i && (role_o == lec_pkg::ROLE_LEADER);

endmodule
